// ----- rtl/nxy_pkg.sv -----
// Package with the shared types, constants and the saturating-increment helper of the neutron x/y decoder.
package nxy_pkg;

    localparam logic [7:0] HDR_HIT   = 8'h5A;
    localparam logic [7:0] HDR_PULSE = 8'h5B;
    localparam logic [7:0] HDR_CLOCK = 8'h5C;

    // Highest axis number that is kept (0 is x, 1 is y).
    localparam logic [2:0] AXIS_LAST = 3'd1;

    localparam int unsigned PHA_W   = 12;
    localparam int unsigned SUM_W   = 13;
    localparam int unsigned TOTAL_W = 11;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned WIN_W   = 25;
    localparam int unsigned PID_W   = 40;
    localparam int unsigned CID_W   = 30;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_W   = 25;

    localparam logic [TOTAL_W-1:0] PHA_MAX           = 11'd1024;
    localparam logic [TOTAL_W-1:0] LOWER_LEVEL_RESET = 11'd128;
    localparam logic [WIN_W-1:0]   WINDOW_RESET      = 25'd32;

    localparam int unsigned DIV_STEPS = POS_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam int unsigned IN_DEPTH_DEFAULT  = 2;
    localparam int unsigned OUT_DEPTH_DEFAULT = 2;

    typedef enum logic [0:0] {
        REG_LOWER_LEVEL,
        REG_WINDOW
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_HIT,
        KIND_PULSE,
        KIND_CLOCK
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t           kind;
        logic [TIME_W-1:0]   tick;
        logic                axis;
        logic [PHA_W-1:0]    left;
        logic [SUM_W-1:0]    sum;
        logic [TOTAL_W-1:0]  total;
        logic [PID_W-1:0]    pulse_id;
        logic [CID_W-1:0]    clock_id;
    } rec_t;

    typedef struct packed {
        logic                event_valid;
        logic [POS_W-1:0]    x_position;
        logic [POS_W-1:0]    y_position;
        logic [TIME_W-1:0]   tick_time;
        logic [TOTAL_W-1:0]  pulse_height;
        logic [PID_W-1:0]    pulse_id;
        logic [CID_W-1:0]    clock_id;
        logic [CID_W-1:0]    start_clock_id;
        logic [CNT_W-1:0]    pulse_count;
        logic [CNT_W-1:0]    clock_count;
        logic [CNT_W-1:0]    pair_count;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [PHA_W-1:0] left;
        logic [SUM_W-1:0] sum;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [POS_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
        logic [CNT_W-1:0] result;
        result = (value == '1) ? value : value + 1'b1;
        return result;
    endfunction

endpackage

// ----- rtl/nxy_fifo.sv -----
// Small first-in first-out queue of packed items, used between the decoder stages.
module nxy_fifo #(
    parameter type item_t = logic,
    parameter int unsigned DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t din,
    output logic  full,
    input  logic  pop,
    output item_t dout,
    output logic  empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t              storage_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               wr_en;
    logic               rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign dout  = storage_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            storage_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more items than its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with its fill level");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("a transaction into the queue was lost");

endmodule

// ----- rtl/nxy_front.sv -----
// Front stage: decodes one detector record and classifies it for the back stage.
module nxy_front (
    input  logic [7:0]                    header,
    input  logic [7:0]                    byte1,
    input  logic [7:0]                    byte2,
    input  logic [7:0]                    byte3,
    input  logic [7:0]                    byte4,
    input  logic [7:0]                    byte5,
    input  logic [7:0]                    byte6,
    input  logic [7:0]                    byte7,
    input  logic [nxy_pkg::TOTAL_W-1:0]   lower_level,
    output nxy_pkg::rec_t                 rec
);

    import nxy_pkg::*;

    logic [2:0]         axis_num;
    logic [PHA_W-1:0]   left;
    logic [PHA_W-1:0]   right;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] total;
    logic               kept;

    always_comb
    begin
        axis_num = byte4[2:0];
        left     = {byte5, byte6[7:4]};
        right    = {byte6[3:0], byte7};
        sum      = {1'b0, left} + {1'b0, right};
        // A quarter of the sum is the total pulse height on the 1024 scale.
        total    = sum[SUM_W-1:2];
        kept     = (axis_num <= AXIS_LAST) && (total >= lower_level) && (total <= PHA_MAX);

        rec.tick     = {byte1, byte2, byte3};
        rec.axis     = axis_num[0];
        rec.left     = left;
        rec.sum      = sum;
        rec.total    = total;
        rec.pulse_id = {byte3, byte4, byte5, byte6, byte7};
        rec.clock_id = {byte1, byte2, byte3, byte4[7:2]};

        priority if (header == HDR_HIT)
        begin
            rec.kind = kept ? KIND_HIT : KIND_NONE;
        end
        else if (header == HDR_PULSE)
        begin
            rec.kind = KIND_PULSE;
        end
        else if (header == HDR_CLOCK)
        begin
            rec.kind = KIND_CLOCK;
        end
        else
        begin
            rec.kind = KIND_NONE;
        end
    end

endmodule

// ----- rtl/nxy_divider.sv -----
// Iterative restoring divider giving the 17-bit position fraction, one bit per cycle.
module nxy_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  nxy_pkg::div_req_t req,
    output nxy_pkg::div_rsp_t rsp
);

    import nxy_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [POS_W-1:0]    quo_reg;
    logic [SUM_W:0]      trial;
    logic                take;
    logic [SUM_W:0]      diff;

    // The left height never exceeds the sum, so the first step yields the integer
    // bit without a shift; the remaining steps produce the 16 fraction bits.
    always_comb
    begin
        trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        take  = (trial >= {1'b0, sum_reg});
        diff  = trial - {1'b0, sum_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            sum_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                rem_reg <= take ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], take};
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= {1'b0, req.left};
                sum_reg  <= req.sum;
                quo_reg  <= '0;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg != '0) |-> (rem_reg < sum_reg))
        else $error("divider remainder is not below the divisor");

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider reports done while still iterating");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == STEP_W'(DIV_STEPS - 1)) |=> done_reg)
        else $error("divider finished without a done pulse");

endmodule

// ----- rtl/nxy_back.sv -----
// Back stage: holds the hit and id state, forms x/y pairs and emits one result per record.
module nxy_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nxy_pkg::WIN_W-1:0]   window,
    input  nxy_pkg::rec_t               rec,
    input  logic                        rec_valid,
    output logic                        rec_pop,
    output nxy_pkg::div_req_t           div_req,
    input  nxy_pkg::div_rsp_t           div_rsp,
    output nxy_pkg::res_t               res,
    output logic                        res_push,
    input  logic                        out_full
);

    import nxy_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    state_t             state_reg,          state_next;
    rec_t               cur_reg,            cur_next;
    logic [POS_W-1:0]   pos_reg,            pos_next;
    logic               held_valid_reg,     held_valid_next;
    logic [TIME_W-1:0]  held_time_reg,      held_time_next;
    logic               held_axis_reg,      held_axis_next;
    logic [POS_W-1:0]   held_position_reg,  held_position_next;
    logic [PID_W-1:0]   last_pulse_id_reg,  last_pulse_id_next;
    logic [CID_W-1:0]   last_clock_id_reg,  last_clock_id_next;
    logic [CID_W-1:0]   first_clock_id_reg, first_clock_id_next;
    logic               clock_seen_reg,     clock_seen_next;
    logic [CNT_W-1:0]   pulse_records_reg,  pulse_records_next;
    logic [CNT_W-1:0]   clock_records_reg,  clock_records_next;
    logic [CNT_W-1:0]   pair_total_reg,     pair_total_next;

    logic [TIME_W-1:0]  dt;
    logic               pair;

    always_comb
    begin
        dt   = (cur_reg.tick >= held_time_reg) ? cur_reg.tick - held_time_reg
                                               : held_time_reg - cur_reg.tick;
        pair = held_valid_reg && (held_axis_reg != cur_reg.axis) && ({1'b0, dt} < window);

        state_next          = state_reg;
        cur_next            = cur_reg;
        pos_next            = pos_reg;
        held_valid_next     = held_valid_reg;
        held_time_next      = held_time_reg;
        held_axis_next      = held_axis_reg;
        held_position_next  = held_position_reg;
        last_pulse_id_next  = last_pulse_id_reg;
        last_clock_id_next  = last_clock_id_reg;
        first_clock_id_next = first_clock_id_reg;
        clock_seen_next     = clock_seen_reg;
        pulse_records_next  = pulse_records_reg;
        clock_records_next  = clock_records_reg;
        pair_total_next     = pair_total_reg;

        rec_pop       = 1'b0;
        res_push      = 1'b0;
        div_req.start = 1'b0;
        div_req.left  = rec.left;
        div_req.sum   = rec.sum;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_pop  = 1'b1;
                    cur_next = rec;
                    pos_next = '0;
                    // A kept hit with a zero sum sits at position zero and needs no division.
                    if (rec.kind == KIND_HIT && rec.sum != '0)
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = div_rsp.quotient;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (cur_reg.kind)
                        KIND_HIT:
                        begin
                            if (pair)
                            begin
                                res.event_valid  = 1'b1;
                                res.x_position   = held_axis_reg ? pos_reg : held_position_reg;
                                res.y_position   = held_axis_reg ? held_position_reg : pos_reg;
                                res.tick_time    = cur_reg.tick;
                                res.pulse_height = cur_reg.total;
                                pair_total_next  = sat_inc(pair_total_reg);
                            end
                            held_valid_next    = 1'b1;
                            held_time_next     = cur_reg.tick;
                            held_axis_next     = cur_reg.axis;
                            held_position_next = pos_reg;
                        end
                        KIND_PULSE:
                        begin
                            last_pulse_id_next = cur_reg.pulse_id;
                            pulse_records_next = sat_inc(pulse_records_reg);
                        end
                        KIND_CLOCK:
                        begin
                            last_clock_id_next = cur_reg.clock_id;
                            if (!clock_seen_reg)
                            begin
                                first_clock_id_next = cur_reg.clock_id;
                                clock_seen_next     = 1'b1;
                            end
                            clock_records_next = sat_inc(clock_records_reg);
                        end
                        KIND_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.pulse_id       = last_pulse_id_next;
        res.clock_id       = last_clock_id_next;
        res.start_clock_id = first_clock_id_next;
        res.pulse_count    = pulse_records_next;
        res.clock_count    = clock_records_next;
        res.pair_count     = pair_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cur_reg            <= '0;
            pos_reg            <= '0;
            held_valid_reg     <= 1'b0;
            held_time_reg      <= '0;
            held_axis_reg      <= 1'b0;
            held_position_reg  <= '0;
            last_pulse_id_reg  <= '0;
            last_clock_id_reg  <= '0;
            first_clock_id_reg <= '0;
            clock_seen_reg     <= 1'b0;
            pulse_records_reg  <= '0;
            clock_records_reg  <= '0;
            pair_total_reg     <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            cur_reg            <= cur_next;
            pos_reg            <= pos_next;
            held_valid_reg     <= held_valid_next;
            held_time_reg      <= held_time_next;
            held_axis_reg      <= held_axis_next;
            held_position_reg  <= held_position_next;
            last_pulse_id_reg  <= last_pulse_id_next;
            last_clock_id_reg  <= last_clock_id_next;
            first_clock_id_reg <= first_clock_id_next;
            clock_seen_reg     <= clock_seen_next;
            pulse_records_reg  <= pulse_records_next;
            clock_records_reg  <= clock_records_next;
            pair_total_reg     <= pair_total_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (cur_reg.kind == KIND_HIT))
        else $error("division running for a record that is not a kept hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.event_valid) |-> (cur_reg.kind == KIND_HIT && held_valid_reg))
        else $error("pair reported without two kept hits");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (pair_total_reg >= $past(pair_total_reg)))
        else $error("pair counter went backwards");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (!div_rsp.busy && state_reg == ST_IDLE))
        else $error("divider started while busy");

endmodule

// ----- rtl/neutron_xy_coincidence_decoder.sv -----
// Top level of the neutron x/y coincidence decoder: configuration, queues and stages.
// A record accepted into the input queue is popped and registered by the back stage, then
// written to the output queue; a kept hit with a non-zero pulse-height sum first goes
// through the 17-step position divider. Records go one at a time; a full output queue stalls.
// Reset clears all held state, ids and counters, empties both queues and loads
// lower_level with 128 and coincidence_window with 32.
module neutron_xy_coincidence_decoder #(
    parameter int unsigned IN_DEPTH  = nxy_pkg::IN_DEPTH_DEFAULT,
    parameter int unsigned OUT_DEPTH = nxy_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  nxy_pkg::cfg_idx_t             cfg_index,
    input  logic [nxy_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    header,
    input  logic [7:0]                    byte1,
    input  logic [7:0]                    byte2,
    input  logic [7:0]                    byte3,
    input  logic [7:0]                    byte4,
    input  logic [7:0]                    byte5,
    input  logic [7:0]                    byte6,
    input  logic [7:0]                    byte7,
    output logic                          empty,
    input  logic                          pop,
    output logic                          event_valid,
    output logic [nxy_pkg::POS_W-1:0]     x_position,
    output logic [nxy_pkg::POS_W-1:0]     y_position,
    output logic [nxy_pkg::TIME_W-1:0]    tick_time,
    output logic [nxy_pkg::TOTAL_W-1:0]   pulse_height,
    output logic [nxy_pkg::PID_W-1:0]     pulse_id,
    output logic [nxy_pkg::CID_W-1:0]     clock_id,
    output logic [nxy_pkg::CID_W-1:0]     start_clock_id,
    output logic [nxy_pkg::CNT_W-1:0]     pulse_count,
    output logic [nxy_pkg::CNT_W-1:0]     clock_count,
    output logic [nxy_pkg::CNT_W-1:0]     pair_count
);

    import nxy_pkg::*;

    logic [TOTAL_W-1:0] lower_level_reg;
    logic [WIN_W-1:0]   window_reg;
    rec_t               front_rec;
    rec_t               queued_rec;
    logic               rec_empty;
    logic               rec_pop;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    res_t               back_res;
    res_t               out_res;
    logic               res_push;
    logic               res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_level_reg <= LOWER_LEVEL_RESET;
            window_reg      <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOWER_LEVEL: lower_level_reg <= cfg_data[TOTAL_W-1:0];
                REG_WINDOW:      window_reg      <= cfg_data[WIN_W-1:0];
                default:         window_reg      <= window_reg;
            endcase
        end
    end

    nxy_front u_front (
        .header      (header),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .byte4       (byte4),
        .byte5       (byte5),
        .byte6       (byte6),
        .byte7       (byte7),
        .lower_level (lower_level_reg),
        .rec         (front_rec)
    );

    nxy_fifo #(
        .item_t (rec_t),
        .DEPTH  (IN_DEPTH)
    ) u_rec_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_rec),
        .full  (full),
        .pop   (rec_pop),
        .dout  (queued_rec),
        .empty (rec_empty)
    );

    nxy_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    nxy_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .window    (window_reg),
        .rec       (queued_rec),
        .rec_valid (!rec_empty),
        .rec_pop   (rec_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res       (back_res),
        .res_push  (res_push),
        .out_full  (res_full)
    );

    nxy_fifo #(
        .item_t (res_t),
        .DEPTH  (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign event_valid    = out_res.event_valid;
    assign x_position     = out_res.x_position;
    assign y_position     = out_res.y_position;
    assign tick_time      = out_res.tick_time;
    assign pulse_height   = out_res.pulse_height;
    assign pulse_id       = out_res.pulse_id;
    assign clock_id       = out_res.clock_id;
    assign start_clock_id = out_res.start_clock_id;
    assign pulse_count    = out_res.pulse_count;
    assign clock_count    = out_res.clock_count;
    assign pair_count     = out_res.pair_count;

endmodule

// ----- tb/tb.sv -----
// Testbench for the neutron x/y coincidence decoder: directed records, then random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nxy_pkg::*;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } record_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        record_t          rec;
        bit               pinned;
        res_t             want;
        logic [CFG_W-1:0] lvl_word;
        logic [CFG_W-1:0] win_word;
    } step_t;

    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned ITEMS_PER_PHASE = 191;
    localparam int unsigned SETTLE_CYCLES   = 24;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    cfg_idx_t            cfg_index = REG_LOWER_LEVEL;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [7:0]          header = '0;
    logic [7:0]          byte1 = '0;
    logic [7:0]          byte2 = '0;
    logic [7:0]          byte3 = '0;
    logic [7:0]          byte4 = '0;
    logic [7:0]          byte5 = '0;
    logic [7:0]          byte6 = '0;
    logic [7:0]          byte7 = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic                event_valid;
    logic [POS_W-1:0]    x_position;
    logic [POS_W-1:0]    y_position;
    logic [TIME_W-1:0]   tick_time;
    logic [TOTAL_W-1:0]  pulse_height;
    logic [PID_W-1:0]    pulse_id;
    logic [CID_W-1:0]    clock_id;
    logic [CID_W-1:0]    start_clock_id;
    logic [CNT_W-1:0]    pulse_count;
    logic [CNT_W-1:0]    clock_count;
    logic [CNT_W-1:0]    pair_count;

    // A typed-in expectation travels with its record, so it lines up with the acceptance.
    bit                  pin_on = 1'b0;
    res_t                pin_res = '0;

    // Predictor state and its copy of the registers.
    logic [TOTAL_W-1:0]  lvl_cfg = LOWER_LEVEL_RESET;
    logic [WIN_W-1:0]    win_cfg = WINDOW_RESET;
    bit                  hit_held = 1'b0;
    logic [TIME_W-1:0]   hit_time = '0;
    logic                hit_axis = 1'b0;
    logic [POS_W-1:0]    hit_pos = '0;
    logic [PID_W-1:0]    pid_latched = '0;
    logic [CID_W-1:0]    cid_latched = '0;
    logic [CID_W-1:0]    cid_first = '0;
    bit                  cid_seen = 1'b0;
    logic [CNT_W-1:0]    n_pulse = '0;
    logic [CNT_W-1:0]    n_clock = '0;
    logic [CNT_W-1:0]    n_pair = '0;

    res_t                decoded_q[$];
    step_t               plan[$];
    int                  n_errors = 0;
    int                  n_records = 0;
    int                  n_checked = 0;
    int                  n_pairs = 0;
    int                  n_settings = 0;
    int                  rx_mode = 0;
    int                  rx_left = 0;
    logic [TIME_W-1:0]   stim_tick = '0;

    neutron_xy_coincidence_decoder i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic res_t decode_record(record_t r);
        res_t             o;
        logic [TIME_W-1:0] t;
        logic [2:0]       ax;
        logic [PHA_W-1:0] l_ph;
        logic [PHA_W-1:0] r_ph;
        logic [31:0]      word;
        int unsigned      sum;
        int unsigned      total;
        int unsigned      pos;
        int unsigned      dt;
        o = '0;
        case (r.header)
            HDR_HIT:
            begin
                t     = {r.byte1, r.byte2, r.byte3};
                ax    = r.byte4[2:0];
                l_ph  = {r.byte5, r.byte6[7:4]};
                r_ph  = {r.byte6[3:0], r.byte7};
                sum   = l_ph + r_ph;
                total = sum / 4;
                pos   = (sum == 0) ? 0 : (l_ph * 65536) / sum;
                if (ax <= AXIS_LAST && total >= lvl_cfg && total <= PHA_MAX)
                begin
                    if (hit_held && hit_axis != ax[0])
                    begin
                        dt = (t >= hit_time) ? t - hit_time : hit_time - t;
                        if (dt < win_cfg)
                        begin
                            o.event_valid = 1'b1;
                            if (hit_axis == 1'b0)
                            begin
                                o.x_position = hit_pos;
                                o.y_position = POS_W'(pos);
                            end
                            else
                            begin
                                o.x_position = POS_W'(pos);
                                o.y_position = hit_pos;
                            end
                            o.tick_time    = t;
                            o.pulse_height = TOTAL_W'(total);
                            n_pair = (n_pair == '1) ? n_pair : n_pair + 1'b1;
                        end
                    end
                    hit_held = 1'b1;
                    hit_time = t;
                    hit_axis = ax[0];
                    hit_pos  = POS_W'(pos);
                end
            end
            HDR_PULSE:
            begin
                pid_latched = {r.byte3, r.byte4, r.byte5, r.byte6, r.byte7};
                n_pulse = (n_pulse == '1) ? n_pulse : n_pulse + 1'b1;
            end
            HDR_CLOCK:
            begin
                word = {r.byte1, r.byte2, r.byte3, r.byte4};
                cid_latched = word[31:2];
                if (!cid_seen)
                begin
                    cid_first = cid_latched;
                    cid_seen  = 1'b1;
                end
                n_clock = (n_clock == '1) ? n_clock : n_clock + 1'b1;
            end
            default:
            begin
            end
        endcase
        o.pulse_id       = pid_latched;
        o.clock_id       = cid_latched;
        o.start_clock_id = cid_first;
        o.pulse_count    = n_pulse;
        o.clock_count    = n_clock;
        o.pair_count     = n_pair;
        return o;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    function automatic res_t want(logic ev, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                  logic [TIME_W-1:0] tick, logic [TOTAL_W-1:0] ph,
                                  logic [PID_W-1:0] pid, logic [CID_W-1:0] cid,
                                  logic [CID_W-1:0] scid, logic [CNT_W-1:0] pc,
                                  logic [CNT_W-1:0] cc, logic [CNT_W-1:0] prs);
        res_t o;
        o = {ev, x, y, tick, ph, pid, cid, scid, pc, cc, prs};
        return o;
    endfunction

    function automatic step_t item_row(record_t rec);
        step_t s;
        s = '{ROW_ITEM, rec, 1'b0, '0, '0, '0};
        return s;
    endfunction

    function automatic step_t pinned_row(record_t rec, res_t w);
        step_t s;
        s = '{ROW_ITEM, rec, 1'b1, w, '0, '0};
        return s;
    endfunction

    function automatic step_t cfg_row(logic [CFG_W-1:0] lvl_word, logic [CFG_W-1:0] win_word);
        step_t s;
        s = '{ROW_CFG, '0, 1'b0, '0, lvl_word, win_word};
        return s;
    endfunction

    // Drives one record and returns at the edge where it was taken.
    task automatic offer(record_t rec, bit pin, res_t w);
        push <= 1'b1;
        {header, byte1, byte2, byte3, byte4, byte5, byte6, byte7} <= rec;
        pin_on  <= pin;
        pin_res <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    // One edge first, so that a record taken at the calling edge is already in the queue.
    task automatic settle();
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(logic [CFG_W-1:0] lvl_word, logic [CFG_W-1:0] win_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOWER_LEVEL;
        cfg_data  <= lvl_word;
        @(posedge clk);
        cfg_index <= REG_WINDOW;
        cfg_data  <= win_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Checks each result taken and predicts each record taken at the same edge.
    always @(posedge clk)
    begin : scoreboard
        res_t got;
        res_t fresh;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = {event_valid, x_position, y_position, tick_time, pulse_height,
                       pulse_id, clock_id, start_clock_id, pulse_count, clock_count,
                       pair_count};
                if (decoded_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with nothing outstanding, expected none, got %0h",
                             $time, got);
                end
                else
                begin
                    fresh = decoded_q.pop_front();
                    check_field("event_valid", fresh.event_valid, got.event_valid);
                    check_field("x_position", fresh.x_position, got.x_position);
                    check_field("y_position", fresh.y_position, got.y_position);
                    check_field("tick_time", fresh.tick_time, got.tick_time);
                    check_field("pulse_height", fresh.pulse_height, got.pulse_height);
                    check_field("pulse_id", fresh.pulse_id, got.pulse_id);
                    check_field("clock_id", fresh.clock_id, got.clock_id);
                    check_field("start_clock_id", fresh.start_clock_id, got.start_clock_id);
                    check_field("pulse_count", fresh.pulse_count, got.pulse_count);
                    check_field("clock_count", fresh.clock_count, got.clock_count);
                    check_field("pair_count", fresh.pair_count, got.pair_count);
                    n_checked++;
                    if (got.event_valid)
                        n_pairs++;
                end
            end
            if (push && !full)
            begin
                fresh = decode_record({header, byte1, byte2, byte3, byte4, byte5, byte6,
                                       byte7});
                decoded_q.push_back(pin_on ? pin_res : fresh);
                n_records++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOWER_LEVEL: lvl_cfg = cfg_data[TOTAL_W-1:0];
                    REG_WINDOW:      win_cfg = cfg_data[WIN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // The result side switches between steady, random, sparse and periodic readiness.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= rx_left[2];
        endcase
    end

    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned       span;
        int unsigned       sum;
        int unsigned       lo;
        int unsigned       l_ph;
        int unsigned       r_ph;
        int                pick;
        int                gap;
        int                burst_left;
        logic [2:0]        axis;
        logic [TOTAL_W-1:0] lvl;
        logic [WIN_W-1:0]  win;
        bit                quiet;
        record_t           rec;

        // Rows with a typed expectation start from reset values (level 128, window 32).
        plan.push_back(pinned_row(64'h00_00_00_00_00_00_00_00,
                                  want(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(pinned_row(64'hFF_FF_FF_FF_FF_FF_FF_FF,
                                  want(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(pinned_row(64'h5B_FF_FF_FF_FF_FF_FF_FF,
                                  want(0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 0, 0, 1, 0, 0)));
        plan.push_back(pinned_row(64'h5C_FF_FF_FF_FF_00_00_00,
                                  want(0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 30'h3FFF_FFFF,
                                       30'h3FFF_FFFF, 1, 1, 0)));
        plan.push_back(pinned_row(64'h5C_00_00_00_00_FF_FF_FF,
                                  want(0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 0, 30'h3FFF_FFFF,
                                       1, 2, 0)));
        plan.push_back(pinned_row(64'h5A_00_00_00_00_20_02_00,
                                  want(0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 0, 30'h3FFF_FFFF,
                                       1, 2, 0)));
        plan.push_back(pinned_row(64'h5A_00_00_1F_01_00_08_00,
                                  want(1, 17'h08000, 0, 24'h1F, 512, 40'hFF_FFFF_FFFF, 0,
                                       30'h3FFF_FFFF, 1, 2, 1)));
        // A time difference equal to the window does not pair.
        plan.push_back(pinned_row(64'h5A_00_00_3F_00_80_00_00,
                                  want(0, 0, 0, 0, 0, 40'hFF_FFFF_FFFF, 0, 30'h3FFF_FFFF,
                                       1, 2, 1)));
        plan.push_back(pinned_row(64'h5A_00_00_40_01_20_02_00,
                                  want(1, 17'h10000, 17'h08000, 24'h40, 256, 40'hFF_FFFF_FFFF,
                                       0, 30'h3FFF_FFFF, 1, 2, 2)));
        plan.push_back(item_row(64'h5A_00_00_40_01_20_02_00));
        plan.push_back(item_row(64'h5A_00_00_41_FA_20_02_00));
        plan.push_back(item_row(64'h5A_00_00_41_07_20_02_00));
        plan.push_back(item_row(64'h5A_00_00_41_00_FF_FF_FF));
        plan.push_back(item_row(64'h5A_00_00_41_00_80_08_00));
        plan.push_back(item_row(64'h5A_00_00_42_01_80_48_00));
        plan.push_back(item_row(64'h5A_00_00_42_01_1F_F0_01));
        plan.push_back(item_row(64'h5A_00_00_43_00_1F_E0_01));
        plan.push_back(item_row(64'h5A_FF_FF_FF_00_20_02_00));
        plan.push_back(item_row(64'h5A_FF_FF_E1_01_10_03_00));
        // Level 0 with junk above the register width, widest window.
        plan.push_back(cfg_row(25'h1FF_F800, 25'h100_0000));
        plan.push_back(item_row(64'h5A_00_00_00_00_00_00_00));
        plan.push_back(item_row(64'h5A_FF_FF_FF_01_00_10_00));
        plan.push_back(cfg_row(25'd1024, 25'd0));
        plan.push_back(item_row(64'h5A_00_01_00_00_80_08_00));
        plan.push_back(item_row(64'h5A_00_01_00_01_80_38_00));
        plan.push_back(item_row(64'h5A_00_01_00_00_FF_F0_00));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                push <= 1'b0;
                settle();
                set_registers(plan[i].lvl_word, plan[i].win_word);
            end
            else
                offer(plan[i].rec, plan[i].pinned, plan[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            push <= 1'b0;
            settle();
            case ($urandom_range(0, 5))
                0:       lvl = 0;
                1:       lvl = 1024;
                default: lvl = $urandom_range(0, 300);
            endcase
            case ($urandom_range(0, 5))
                0:       win = 0;
                1:       win = 25'h100_0000;
                2:       win = $urandom_range(1, 64);
                3:       win = $urandom_range(0, 16777216);
                default: win = $urandom_range(16, 2000);
            endcase
            set_registers({14'($urandom_range(0, 16383)), lvl}, win);
            span       = (win > 3000) ? 3000 : win + 4;
            quiet      = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (!quiet && burst_left == 0)
                begin
                    gap = $urandom_range(1, 12);
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                    burst_left = $urandom_range(1, 40);
                end
                if (burst_left > 0)
                    burst_left--;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // Hits mostly walk forward in time so that pairs form within the window.
                    if ($urandom_range(0, 9) == 0)
                        stim_tick = 24'($urandom);
                    else if ($urandom_range(0, 5) == 0)
                        stim_tick = stim_tick - 24'($urandom_range(0, span));
                    else
                        stim_tick = stim_tick + 24'($urandom_range(0, span));
                    axis = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(2, 7))
                                                       : 3'($urandom_range(0, 1));
                    if (lvl <= 1024 && $urandom_range(0, 7) != 0)
                    begin
                        lo   = 4 * lvl;
                        sum  = $urandom_range(lo, 4099);
                        l_ph = $urandom_range((sum > 4095) ? sum - 4095 : 0,
                                              (sum > 4095) ? 4095 : sum);
                        r_ph = sum - l_ph;
                    end
                    else
                    begin
                        l_ph = $urandom_range(0, 4095);
                        r_ph = $urandom_range(0, 4095);
                    end
                    rec = {HDR_HIT, stim_tick, 5'($urandom), axis, 12'(l_ph), 12'(r_ph)};
                end
                else if (pick < 82)
                    rec = {HDR_PULSE, 24'($urandom), 32'($urandom)};
                else if (pick < 94)
                    rec = {HDR_CLOCK, 32'($urandom), 24'($urandom)};
                else
                    rec = {8'($urandom), 24'($urandom), 32'($urandom)};
                offer(rec, 1'b0, '0);
            end
        end

        push <= 1'b0;
        settle();
        $display("Decoded %0d records and checked %0d results, %0d of them x/y pairs,",
                 n_records, n_checked, n_pairs);
        $display("across %0d register settings.", n_settings);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
